// ===== hw/rtl/bounded_deque_unit_macros.svh =====
// Assertion macros for the bounded deque unit.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef BOUNDED_DEQUE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define BDQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define BDQ_ASSERT_IMPL(label, ante, cons, msg)
`define BDQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

    // Operation codes
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_DEL_FRONT = 3'd2;
    localparam logic [2:0] OP_DEL_BACK  = 3'd3;
    localparam logic [2:0] OP_LIST      = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int unsigned DATA_W = 32;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } t_out_item;

endpackage

// ===== hw/rtl/bdq_store.sv =====
`timescale 1ns / 1ps

// Element store: one write port, one read port, registered read data.
// Read data holds while no read is issued.
module bdq_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bounded_deque_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+------------------------------
// input    | in        | i_in_valid / o_in_ready    | i_in_data  (operation, value)
// output   | out       | o_out_valid / i_out_ready  | o_out_data (status, element, last)
//
// An accepted item lands in a one-entry command register and executes from there
// once the output register is free; inserts and deletes then sustain one transfer
// per cycle while the output is not stalled. A list streams one element per cycle
// from the store's single registered read port while the output is not stalled.
// Synchronous active-low reset empties the deque; the store itself is not cleared.
// A stall on the output holds the output register, the read data and the command.

`include "bounded_deque_unit_macros.svh"

module bounded_deque_unit #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bdq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bdq_pkg::t_out_item o_out_data
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned DW = bdq_pkg::DATA_W;

    localparam logic [AW-1:0] LAST_POS = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [AW:0]   CAP_SUM  = (AW + 1)'(CAPACITY);

    typedef enum logic [0:0] {
        S_IDLE,
        S_LIST
    } t_state;

    // Step a position forward or back around the ring.
    function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] pos_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_POS : p - 1'b1;
    endfunction

    // Registers
    t_state              r_state,     n_state;
    logic                r_cmd_valid, n_cmd_valid;
    bdq_pkg::t_in_item   r_cmd,       n_cmd;
    logic [AW-1:0]       r_front,     n_front;
    logic [CW-1:0]       r_count,     n_count;
    logic [CW-1:0]       r_iss,       n_iss;
    logic [CW-1:0]       r_emit,      n_emit;
    logic [AW-1:0]       r_rpos,      n_rpos;
    logic                r_rd_pend,   n_rd_pend;
    logic                r_out_valid, n_out_valid;
    bdq_pkg::t_out_item  r_out_data,  n_out_data;

    // Store access
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [DW-1:0] mem_rdata;

    // Control
    logic               out_free;
    logic               out_load;
    bdq_pkg::t_out_item load_data;
    logic               cmd_done;
    logic               in_xfer;
    logic               is_full;
    logic               is_empty;
    logic [AW:0]        back_sum;
    logic [AW-1:0]      back_pos;
    logic               rd_take;
    logic               rd_issue;
    logic               list_last;

    bdq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_cmd.value),
        .i_re    (mem_re),
        .i_raddr (r_rpos),
        .o_rdata (mem_rdata)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign is_full  = (r_count == CAP_CNT);
    assign is_empty = (r_count == '0);

    // Back slot: front + count, wrapped once. Only used when not full, so the
    // count fits the position width.
    assign back_sum = (AW + 1)'(r_front) + (AW + 1)'(r_count);
    assign back_pos = (back_sum >= CAP_SUM) ? AW'(back_sum - CAP_SUM) : AW'(back_sum);

    // List streaming: issue a read when the read register is free or drains
    // this cycle; hand read data to the output register when it is free.
    assign rd_take   = (r_state == S_LIST) && r_rd_pend && out_free;
    assign rd_issue  = (r_state == S_LIST) && (r_iss != r_count) && (!r_rd_pend || rd_take);
    assign list_last = ((r_emit + 1'b1) == r_count);

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_iss     = r_iss;
        n_emit    = r_emit;
        n_rpos    = r_rpos;
        n_rd_pend = r_rd_pend;
        mem_we    = 1'b0;
        mem_waddr = back_pos;
        mem_re    = 1'b0;
        out_load  = 1'b0;
        load_data = '{status: bdq_pkg::ST_OK, element: '0, last: 1'b1};
        cmd_done  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (r_cmd_valid) begin
                    unique case (r_cmd.operation)
                        bdq_pkg::OP_INS_FRONT: begin
                            if (out_free) begin
                                out_load = 1'b1;
                                cmd_done = 1'b1;
                                if (is_full) begin
                                    load_data.status = bdq_pkg::ST_FULL;
                                end else begin
                                    mem_we    = 1'b1;
                                    mem_waddr = pos_dec(r_front);
                                    n_front   = pos_dec(r_front);
                                    n_count   = r_count + 1'b1;
                                end
                            end
                        end
                        bdq_pkg::OP_INS_BACK: begin
                            if (out_free) begin
                                out_load = 1'b1;
                                cmd_done = 1'b1;
                                if (is_full) begin
                                    load_data.status = bdq_pkg::ST_FULL;
                                end else begin
                                    mem_we    = 1'b1;
                                    mem_waddr = back_pos;
                                    n_count   = r_count + 1'b1;
                                end
                            end
                        end
                        bdq_pkg::OP_DEL_FRONT: begin
                            if (out_free) begin
                                out_load = 1'b1;
                                cmd_done = 1'b1;
                                if (is_empty) begin
                                    load_data.status = bdq_pkg::ST_EMPTY;
                                end else begin
                                    n_front = pos_inc(r_front);
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        bdq_pkg::OP_DEL_BACK: begin
                            if (out_free) begin
                                out_load = 1'b1;
                                cmd_done = 1'b1;
                                if (is_empty) begin
                                    load_data.status = bdq_pkg::ST_EMPTY;
                                end else begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        bdq_pkg::OP_LIST: begin
                            if (is_empty) begin
                                if (out_free) begin
                                    out_load         = 1'b1;
                                    cmd_done         = 1'b1;
                                    load_data.status = bdq_pkg::ST_EMPTY;
                                end
                            end else begin
                                // Start the walk at the front; the command stays
                                // held until the last element is loaded for output.
                                n_state   = S_LIST;
                                n_iss     = '0;
                                n_emit    = '0;
                                n_rpos    = r_front;
                                n_rd_pend = 1'b0;
                            end
                        end
                        default: begin
                            // Unused codes: drop without a result.
                            cmd_done = 1'b1;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (rd_issue) begin
                    mem_re = 1'b1;
                    n_rpos = pos_inc(r_rpos);
                    n_iss  = r_iss + 1'b1;
                end
                n_rd_pend = rd_issue || (r_rd_pend && !rd_take);
                if (rd_take) begin
                    out_load          = 1'b1;
                    load_data.element = mem_rdata;
                    load_data.last    = list_last;
                    n_emit            = r_emit + 1'b1;
                    if (list_last) begin
                        n_state  = S_IDLE;
                        cmd_done = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Command register: take a new item when empty or when the held one retires.
    assign o_in_ready  = !r_cmd_valid || cmd_done;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign n_cmd_valid = in_xfer || (r_cmd_valid && !cmd_done);
    assign n_cmd       = in_xfer ? i_in_data : r_cmd;

    // Output register: load a result, otherwise hold until the transfer.
    assign n_out_valid = out_load || (r_out_valid && !i_out_ready);
    assign n_out_data  = out_load ? load_data : r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd_valid <= 1'b0;
            r_front     <= '0;
            r_count     <= '0;
            r_iss       <= '0;
            r_emit      <= '0;
            r_rpos      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd_valid <= n_cmd_valid;
            r_front     <= n_front;
            r_count     <= n_count;
            r_iss       <= n_iss;
            r_emit      <= n_emit;
            r_rpos      <= n_rpos;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Assertions
    `BDQ_ASSERT_IMPL(a_count_bound, 1'b1, (r_count <= CAP_CNT) && (r_front <= LAST_POS), "deque count or front position out of range")
    `BDQ_ASSERT_IMPL(a_list_order, r_state == S_LIST, (r_emit <= r_iss) && (r_iss <= r_count), "list read and emit counters out of order")
    `BDQ_ASSERT_IMPL(a_write_idle, mem_we, (r_state == S_IDLE) && r_cmd_valid && out_load, "store written outside an executing command")
    `BDQ_ASSERT_NEXT(a_list_stable, (r_state == S_LIST) && !cmd_done, r_cmd_valid && $stable(r_count) && $stable(r_front), "deque changed during a list")

endmodule

// ===== tb/sv/tb_bounded_deque_unit.sv =====
`timescale 1ns / 1ps

module tb_bounded_deque_unit;
    import bdq_pkg::*;

    localparam int unsigned DEPTH = 64;

    // Opcodes the block must ignore: no state change, no result
    localparam logic [2:0] OP_RSVD_A = 3'd5;
    localparam logic [2:0] OP_RSVD_B = 3'd6;
    localparam logic [2:0] OP_RSVD_C = 3'd7;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    bounded_deque_unit #(
        .CAPACITY (DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stimulus not yet presented, and results owed by the block in order
    t_in_item  pending_items[$];
    t_out_item awaited_results[$];
    int        err_count = 0;

    // Occupancy as seen by the stimulus generator, used only to steer phases
    int        gen_count = 0;

    // Shadow deque: ring storage, front index and occupancy
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    bit [5:0]                 shadow_front = '0;
    bit [6:0]                 shadow_count = '0;

    // Apply one accepted operation to the shadow deque and queue the results it owes.
    task automatic deque_apply(input t_in_item it);
        t_out_item  res;
        logic [5:0] pos;
        res = '0;
        res.last = 1'b1;
        case (it.operation)
            OP_INS_FRONT, OP_INS_BACK: begin
                if (shadow_count == DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (it.operation == OP_INS_FRONT) begin
                        shadow_front = 6'((int'(shadow_front) + DEPTH - 1) % DEPTH);
                        pos = shadow_front;
                    end else begin
                        pos = 6'((int'(shadow_front) + int'(shadow_count)) % DEPTH);
                    end
                    shadow_store[pos] = it.value;
                    shadow_count++;
                    res.status = ST_OK;
                end
                awaited_results.push_back(res);
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // Delete from back only shrinks the count
                    if (it.operation == OP_DEL_FRONT) begin
                        shadow_front = 6'((int'(shadow_front) + 1) % DEPTH);
                    end
                    shadow_count--;
                    res.status = ST_OK;
                end
                awaited_results.push_back(res);
            end
            OP_LIST: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                    awaited_results.push_back(res);
                end else begin
                    for (int i = 0; i < int'(shadow_count); i++) begin
                        pos = 6'((int'(shadow_front) + i) % DEPTH);
                        res.status  = ST_OK;
                        res.element = shadow_store[pos];
                        res.last    = (i == int'(shadow_count) - 1);
                        awaited_results.push_back(res);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic queue_item(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
        t_in_item it;
        it.operation = op;
        it.value     = val;
        pending_items.push_back(it);
        if ((op == OP_INS_FRONT || op == OP_INS_BACK) && gen_count < DEPTH) begin
            gen_count++;
        end else if ((op == OP_DEL_FRONT || op == OP_DEL_BACK) && gen_count > 0) begin
            gen_count--;
        end
    endtask

    // Mostly full-range random values, with the extremes mixed in
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Draw one operation; the weights set whether the deque tends to grow or drain.
    task automatic add_random(input int unsigned ins_w, input int unsigned del_w);
        int unsigned r;
        r = $urandom_range(99);
        if (r < ins_w) begin
            queue_item(($urandom_range(1) == 0) ? OP_INS_FRONT : OP_INS_BACK, pick_value());
        end else if (r < ins_w + del_w) begin
            queue_item(($urandom_range(1) == 0) ? OP_DEL_FRONT : OP_DEL_BACK, pick_value());
        end else if (r < 97) begin
            queue_item(OP_LIST, pick_value());
        end else begin
            queue_item(3'($urandom_range(OP_RSVD_A, OP_RSVD_C)), pick_value());
        end
    endtask

    // Stimulus, reset and end of run
    initial begin
        // Directed: empty cases first, then extremes of value, ignored codes, wrap of front
        queue_item(OP_LIST,      32'sd0);
        queue_item(OP_DEL_FRONT, 32'sd17);
        queue_item(OP_DEL_BACK,  32'sd0);
        queue_item(OP_INS_BACK,  32'sh7FFF_FFFF);
        queue_item(OP_INS_FRONT, 32'sh8000_0000);
        queue_item(OP_INS_BACK,  32'sh0000_0000);
        queue_item(OP_INS_FRONT, 32'shFFFF_FFFF);
        queue_item(OP_LIST,      32'sh1234_5678);
        queue_item(OP_RSVD_A,    32'sh7FFF_FFFF);
        queue_item(OP_RSVD_B,    32'sh8000_0000);
        queue_item(OP_RSVD_C,    32'shFFFF_FFFF);
        queue_item(OP_DEL_FRONT, 32'shFFFF_FFFF);
        queue_item(OP_DEL_BACK,  32'sh8000_0000);
        queue_item(OP_LIST,      32'sd0);
        queue_item(OP_INS_FRONT, 32'sh5555_5555);
        queue_item(OP_INS_BACK,  32'shAAAA_AAAA);
        queue_item(OP_LIST,      32'sd0);
        queue_item(OP_DEL_BACK,  32'sd0);
        queue_item(OP_DEL_BACK,  32'sd0);
        queue_item(OP_DEL_FRONT, 32'sd0);
        queue_item(OP_DEL_FRONT, 32'sd0);
        queue_item(OP_DEL_BACK,  32'sd0);
        queue_item(OP_LIST,      32'sd0);

        // Grow to capacity, push past it, then dump the full deque
        while (gen_count < DEPTH) add_random(95, 2);
        repeat (3) add_random(100, 0);
        queue_item(OP_LIST, pick_value());

        // Drain to empty, delete past it, then list the empty deque
        while (gen_count > 0) add_random(2, 95);
        repeat (2) add_random(0, 100);
        queue_item(OP_LIST, pick_value());

        // Balanced traffic around small occupancy
        repeat (4) add_random(45, 45);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait out the stimulus and every owed result, then allow a full list to drain
        while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DEPTH + 8) @(posedge i_clk);

        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Sender: present items in bursts with random gaps; predict on each transfer
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin : item_driver
        logic take_next;
        if (!i_rst_n) begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                deque_apply(in_data);
            end
            // Advance only when nothing is on offer or the offer just transferred
            take_next = !in_valid || o_in_ready;
            if (take_next) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                    if (burst_left <= 1) begin
                        // Now and then a long back-to-back run, otherwise short bursts
                        if ($urandom_range(3) == 0) begin
                            burst_left <= 40;
                            gap_left   <= 0;
                        end else begin
                            burst_left <= $urandom_range(10, 1);
                            gap_left   <= $urandom_range(6);
                        end
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready follows a 16-bit mask, redrawn whenever the position counter wraps.
    // Bit 0 is always set, so ready returns on every pass through the mask.
    logic [15:0] stall_mask = 16'hFFFF;
    logic [5:0]  stall_pos = '0;

    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_pos <= '0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: status %0d element %0d last %0d",
                           o_out_data.status, o_out_data.element, o_out_data.last);
                    err_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                        err_count++;
                    end
                    if (o_out_data.element !== want.element) begin
                        $error("element: expected %0d, got %0d",
                               want.element, o_out_data.element);
                        err_count++;
                    end
                    if (o_out_data.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_out_data.last);
                        err_count++;
                    end
                end
            end
            if (stall_pos == 6'd63) begin
                // A quarter of the windows run with no stalls at all
                stall_mask <= ($urandom_range(3) == 0) ? 16'hFFFF
                                                       : (16'($urandom) | 16'h0001);
            end
            stall_pos <= stall_pos + 6'd1;
            out_ready <= stall_mask[stall_pos[3:0]];
        end
    end

endmodule

// ===== bounded_deque_unit.f =====
+incdir+hw/rtl
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_store.sv
hw/rtl/bounded_deque_unit.sv
tb/sv/tb_bounded_deque_unit.sv
